// ----- hw/rtl/id3fw_pkg.sv -----
// shared types and constants for the id3v2 frame walker
`timescale 1ns / 1ps

package id3fw_pkg;

  // parse phases, one-hot
  typedef enum logic [3:0] {
    PH_TAG_HDR   = 4'b0001,
    PH_FRAME_HDR = 4'b0010,
    PH_PAYLOAD   = 4'b0100,
    PH_DONE      = 4'b1000
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_TITLE   = 2'd0;
  localparam logic [1:0] KIND_ARTIST  = 2'd1;
  localparam logic [1:0] KIND_PICTURE = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;
  localparam logic [1:0] KIND_SKIP    = 2'd3;

  // status codes
  localparam logic [2:0] ST_DATA        = 3'd0;
  localparam logic [2:0] ST_TAG_DONE    = 3'd1;
  localparam logic [2:0] ST_NO_TAG      = 3'd2;
  localparam logic [2:0] ST_SHORT_HDR   = 3'd3;
  localparam logic [2:0] ST_SHORT_FRAME = 3'd4;
  localparam logic [2:0] ST_EARLY_END   = 3'd5;

  localparam logic [7:0]  MARK_I    = 8'h49;
  localparam logic [7:0]  MARK_D    = 8'h44;
  localparam logic [7:0]  MARK_3    = 8'h33;
  localparam logic [31:0] ID_TIT2   = 32'h5449_5432;
  localparam logic [31:0] ID_TPE1   = 32'h5450_4531;
  localparam logic [31:0] ID_APIC   = 32'h4150_4943;
  localparam logic [6:0]  SYNC_MASK = 7'h7F;
  localparam logic [27:0] HDR_LEN   = 28'd10;
  localparam logic [3:0]  HDR_LAST  = 4'd9;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic [2:0] code;
    logic       last_of_run;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } run_t;

  function automatic logic [7:0] tag_mark(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0:    m = MARK_I;
      2'd1:    m = MARK_D;
      default: m = MARK_3;
    endcase
    return m;
  endfunction

endpackage

// ----- hw/rtl/id3fw_parser.sv -----
// parse state and per-byte result generation
`timescale 1ns / 1ps

module id3fw_parser
  import id3fw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  input  logic       stream_end,
  output logic       run_v,
  output run_t       run
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [27:0] tag_len_r, tag_len_nxt;
  logic [27:0] remain_r, remain_nxt;
  logic [31:0] ident_r, ident_nxt;
  logic [27:0] flen_r, flen_nxt;
  logic [27:0] left_r, left_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        first_r, first_nxt;

  res_t        a_res, b_res, c_res;
  logic        a_v, b_v, c_v;
  logic        do_bnd;
  logic [27:0] bnd_rem;

  always_comb begin
    phase_nxt   = phase_r;
    hcnt_nxt    = hcnt_r;
    tag_len_nxt = tag_len_r;
    remain_nxt  = remain_r;
    ident_nxt   = ident_r;
    flen_nxt    = flen_r;
    left_nxt    = left_r;
    kind_nxt    = kind_r;
    first_nxt   = first_r;
    a_v = 1'b0;
    b_v = 1'b0;
    c_v = 1'b0;
    a_res = '0;
    b_res = '0;
    c_res = '0;
    b_res.kind = KIND_STATUS;
    c_res.kind = KIND_STATUS;
    do_bnd  = 1'b0;
    bnd_rem = '0;

    unique case (phase_r)
      PH_TAG_HDR: begin
        if (hcnt_r < 4'd3 && data_byte != tag_mark(hcnt_r[1:0])) begin
          b_v = 1'b1;
          b_res.code = ST_NO_TAG;
          phase_nxt = PH_DONE;
        end else begin
          if (hcnt_r >= 4'd6) tag_len_nxt = {tag_len_r[20:0], data_byte[6:0] & SYNC_MASK};
          hcnt_nxt = hcnt_r + 4'd1;
          if (hcnt_r >= HDR_LAST) begin
            // whole tag body still ahead
            remain_nxt = tag_len_nxt;
            do_bnd     = 1'b1;
            bnd_rem    = tag_len_nxt;
          end
        end
      end
      PH_FRAME_HDR: begin
        remain_nxt = remain_r - 28'd1;
        if (hcnt_r < 4'd4) ident_nxt = {ident_r[23:0], data_byte};
        else if (hcnt_r < 4'd8) flen_nxt = {flen_r[20:0], data_byte[6:0] & SYNC_MASK};
        hcnt_nxt = hcnt_r + 4'd1;
        if (hcnt_r >= HDR_LAST) begin
          if (flen_r > remain_nxt) begin
            b_v = 1'b1;
            b_res.code = ST_SHORT_FRAME;
            phase_nxt = PH_DONE;
          end else begin
            priority if (ident_r == ID_TIT2) kind_nxt = KIND_TITLE;
            else if (ident_r == ID_TPE1) kind_nxt = KIND_ARTIST;
            else if (ident_r == ID_APIC) kind_nxt = KIND_PICTURE;
            else kind_nxt = KIND_SKIP;
            if (flen_r == '0) begin
              do_bnd  = 1'b1;
              bnd_rem = remain_nxt;
            end else begin
              left_nxt  = flen_r;
              first_nxt = 1'b1;
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        remain_nxt = remain_r - 28'd1;
        left_nxt   = left_r - 28'd1;
        first_nxt  = 1'b0;
        if (kind_r != KIND_SKIP) begin
          a_v = 1'b1;
          a_res.kind  = kind_r;
          a_res.data  = data_byte;
          a_res.first = first_r;
          a_res.last  = (left_r == 28'd1);
          a_res.code  = ST_DATA;
        end
        if (left_r == 28'd1) begin
          do_bnd  = 1'b1;
          bnd_rem = remain_nxt;
        end
      end
      default: begin
      end
    endcase

    // frame boundary: tag done, no room for a header, or next header
    if (do_bnd) begin
      if (bnd_rem == '0) begin
        b_v = 1'b1;
        b_res.code = ST_TAG_DONE;
        phase_nxt = PH_DONE;
      end else if (bnd_rem < HDR_LEN) begin
        b_v = 1'b1;
        b_res.code = ST_SHORT_HDR;
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_FRAME_HDR;
        hcnt_nxt  = '0;
        ident_nxt = '0;
        flen_nxt  = '0;
      end
    end

    if (stream_end) begin
      if (phase_nxt != PH_DONE) begin
        c_v = 1'b1;
        c_res.code = (phase_nxt == PH_TAG_HDR) ? ST_NO_TAG : ST_EARLY_END;
      end
      phase_nxt   = PH_TAG_HDR;
      hcnt_nxt    = '0;
      tag_len_nxt = '0;
      remain_nxt  = '0;
      ident_nxt   = '0;
      flen_nxt    = '0;
      left_nxt    = '0;
      kind_nxt    = '0;
      first_nxt   = 1'b0;
    end
  end

  // pack up to two results in order
  always_comb begin
    run = '0;
    priority if (a_v) begin
      run.r0  = a_res;
      run.two = b_v | c_v;
      run.r1  = b_v ? b_res : c_res;
    end else if (b_v) begin
      run.r0  = b_res;
      run.two = c_v;
      run.r1  = c_res;
    end else begin
      run.r0  = c_res;
      run.two = 1'b0;
    end
    if (run.two) run.r1.last_of_run = 1'b1;
    else         run.r0.last_of_run = 1'b1;
    run_v = a_v | b_v | c_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TAG_HDR;
      hcnt_r    <= '0;
      tag_len_r <= '0;
      remain_r  <= '0;
      ident_r   <= '0;
      flen_r    <= '0;
      left_r    <= '0;
      kind_r    <= '0;
      first_r   <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      hcnt_r    <= hcnt_nxt;
      tag_len_r <= tag_len_nxt;
      remain_r  <= remain_nxt;
      ident_r   <= ident_nxt;
      flen_r    <= flen_nxt;
      left_r    <= left_nxt;
      kind_r    <= kind_nxt;
      first_r   <= first_nxt;
    end
  end

endmodule

// ----- hw/rtl/id3fw_run_queue.sv -----
// result queue holding runs of one or two results
`timescale 1ns / 1ps

module id3fw_run_queue
  import id3fw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  run_t push_run,
  output logic full,
  output logic out_v,
  output res_t out_res,
  input  logic out_take
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  run_t                      q_r [QDEPTH];
  logic [PW-1:0]             wr_r, wr_nxt;
  logic [PW-1:0]             rd_r, rd_nxt;
  logic [$clog2(QDEPTH+1)-1:0] cnt_r, cnt_nxt;
  logic                      sel_r, sel_nxt;
  logic                      pop;
  run_t                      head;

  assign head    = q_r[rd_r];
  assign out_v   = (cnt_r != '0);
  assign full    = (cnt_r == QDEPTH[$clog2(QDEPTH+1)-1:0]);
  assign out_res = sel_r ? head.r1 : head.r0;
  assign pop     = out_take && (sel_r || !head.two);

  always_comb begin
    sel_nxt = sel_r;
    if (out_take) sel_nxt = !pop;
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(QDEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(QDEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      sel_r <= 1'b0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
      sel_r <= sel_nxt;
    end
  end

endmodule

// ----- hw/rtl/id3v2_frame_walker.sv -----
// top level of the id3v2 tag frame walker
`timescale 1ns / 1ps
//
// streams a file in one byte per request on the in_ channel (in_stream_end
// marks the last byte of a file) and returns title, artist and picture payload
// bytes plus status events on the out_ channel, one result per request
// both channels use valid/stall: a request moves when valid is high and
// stall is low
// a taken byte waits in the input register and is parsed into the result queue
// when it moves on; its first result is then offered at the queue head and is
// accepted when out_stall is low
// throughput: one byte per cycle while nothing stalls; a byte that causes two
// results (last payload byte plus a status, or a status at end of file) holds
// the output for both, so the rate is set by the single-result output port
// when the receiver stalls, the two-entry result queue fills and in_stall
// rises; nothing is lost or reordered
// reset: the walker returns to the tag header phase, the input register and
// the result queue are emptied; after in_stream_end the walker returns to the
// tag header phase for the next file
//
module id3v2_frame_walker
  import id3fw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_stream_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_first_in_frame,
  output logic       out_last_in_frame,
  output logic [2:0] out_status_code,
  output logic       out_last_of_run
);

  // input register
  logic       stg_v_r, stg_v_nxt;
  logic [7:0] stg_byte_r;
  logic       stg_end_r;

  logic       in_take;
  logic       advance;
  logic       run_v;
  run_t       run;
  logic       q_full;
  res_t       head_res;

  // a byte moves on when it makes no results or the queue has room
  assign advance  = stg_v_r && (!run_v || !q_full);
  assign in_stall = stg_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (in_take)      stg_v_nxt = 1'b1;
    else if (advance) stg_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      stg_byte_r <= in_data_byte;
      stg_end_r  <= in_stream_end;
    end
  end

  id3fw_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .data_byte  (stg_byte_r),
    .stream_end (stg_end_r),
    .run_v      (run_v),
    .run        (run)
  );

  id3fw_run_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (advance && run_v),
    .push_run (run),
    .full     (q_full),
    .out_v    (out_valid),
    .out_res  (head_res),
    .out_take (out_valid && !out_stall)
  );

  assign out_kind           = head_res.kind;
  assign out_byte           = head_res.data;
  assign out_first_in_frame = head_res.first;
  assign out_last_in_frame  = head_res.last;
  assign out_status_code    = head_res.code;
  assign out_last_of_run    = head_res.last_of_run;

  // stall only ever holds a byte that is waiting in the input register
  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stg_v_r)
    else $error("input stall without a held byte");

  // a held byte that is stalled stays in the input register
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> stg_v_r && $stable(stg_byte_r) && $stable(stg_end_r))
    else $error("stalled byte lost");

  // status results never carry payload marks or data
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_STATUS |->
      out_byte == 8'd0 && !out_first_in_frame && !out_last_in_frame)
    else $error("status result with payload fields");

  // data results carry the data code
  a_data_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_STATUS |-> out_status_code == ST_DATA)
    else $error("payload result with a status code");

endmodule
